// ===== hdl/dmarhf_pkg.sv =====
// ----------------------------------------------------------------------------
// dmarhf_pkg
// Shared types and codes for the DMA ring half-flag reader.
// ----------------------------------------------------------------------------
package dmarhf_pkg;

    localparam int REQ_W    = 3;
    localparam int CNT_W    = 9;  // remaining, ring size, read position
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FIRST  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SECOND = 3'd2;
    localparam logic [REQ_W-1:0] REQ_IDLE   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RESYNC = 3'd4;
    localparam logic [REQ_W-1:0] REQ_STORE  = 3'd5;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DATA   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NODATA = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EVENT  = 2'd3;

    typedef struct packed {
        logic                first_half;
        logic                second_half;
        logic                overflow;
        logic                idle;
    } t_flags;

    // result of one item before the store read data joins it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_flags              flags;
    } t_result;

endpackage

// ===== hdl/dmarhf_store.sv =====
// ----------------------------------------------------------------------------
// dmarhf_store
// Byte store of the receive ring: one write port, one registered read port.
// ----------------------------------------------------------------------------
module dmarhf_store #(
    parameter int RING_DEPTH = 256,
    parameter int AW         = 8
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [dmarhf_pkg::BYTE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [dmarhf_pkg::BYTE_W-1:0] o_rdata
);
    import dmarhf_pkg::*;

    logic [BYTE_W-1:0] r_mem [RING_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold the read data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dmarhf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmarhf_ctrl
// Ring state: effective size, read position and flags. Decides each item's
// status and issues the store accesses.
// ----------------------------------------------------------------------------
module dmarhf_ctrl #(
    parameter int RING_DEPTH = 256,
    parameter int AW         = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [dmarhf_pkg::CNT_W-1:0]       i_cfg_size,
    input  logic                               i_accept,
    input  logic [dmarhf_pkg::REQ_W-1:0]       i_req_type,
    input  logic [dmarhf_pkg::CNT_W-1:0]       i_remaining,
    input  logic [dmarhf_pkg::BYTE_W-1:0]      i_store_index,
    output logic                               o_we,
    output logic [AW-1:0]                      o_waddr,
    output logic                               o_re,
    output logic [AW-1:0]                      o_raddr,
    output dmarhf_pkg::t_result                o_result
);
    import dmarhf_pkg::*;

    localparam int TOP = RING_DEPTH - (RING_DEPTH % 2);

    function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] size);
        logic [CNT_W-1:0] s;
        s = {size[CNT_W-1:1], 1'b0};
        if (s < CNT_W'(2)) begin
            s = CNT_W'(2);
        end
        if (32'(s) > TOP) begin
            s = CNT_W'(TOP);
        end
        return s;
    endfunction

    logic [CNT_W-1:0]  r_size;
    logic [CNT_W-1:0]  r_pos;
    t_flags            r_flags;

    logic [CNT_W-1:0]  n_pos;
    t_flags            n_flags;
    logic [STATUS_W-1:0] status;

    logic [CNT_W-2:0]  half;
    logic              filled_to;
    logic [CNT_W-1:0]  cnt;
    logic              in_first;
    logic              half_flag;
    logic [CNT_W-1:0]  pos_inc;
    logic [31:0]       pos_ext;
    logic [31:0]       sidx_ext;

    assign half      = r_size[CNT_W-1:1];
    assign filled_to = i_remaining < r_size;
    assign cnt       = r_size - i_remaining;
    assign in_first  = r_pos < {1'b0, half};
    assign half_flag = in_first ? r_flags.first_half : r_flags.second_half;
    assign pos_inc   = r_pos + CNT_W'(1);

    always_comb begin
        n_pos   = r_pos;
        n_flags = r_flags;
        status  = ST_EVENT;
        unique case (i_req_type)
            REQ_READ: begin
                if (r_flags.overflow) begin
                    status       = ST_OVF;
                    n_flags.idle = 1'b0;
                end else if (half_flag || (filled_to && r_pos < cnt)) begin
                    status       = ST_DATA;
                    n_pos        = pos_inc;
                    n_flags.idle = 1'b0;
                    // leaving a half frees it; idle is kept on that read
                    if (in_first) begin
                        if (pos_inc == {1'b0, half}) begin
                            n_flags.first_half = 1'b0;
                            n_flags.idle       = r_flags.idle;
                        end
                    end else if (pos_inc >= r_size) begin
                        n_pos               = '0;
                        n_flags.second_half = 1'b0;
                        n_flags.idle        = r_flags.idle;
                    end
                end else begin
                    status       = ST_NODATA;
                    n_flags.idle = 1'b0;
                end
            end
            REQ_FIRST: begin
                n_flags.first_half = 1'b1;
                if (r_flags.second_half) begin
                    n_flags.overflow = 1'b1;
                end
            end
            REQ_SECOND: begin
                n_flags.second_half = 1'b1;
                if (r_flags.first_half) begin
                    n_flags.overflow = 1'b1;
                end
            end
            REQ_IDLE: begin
                n_flags.idle = 1'b1;
            end
            REQ_RESYNC: begin
                n_flags.first_half  = 1'b0;
                n_flags.second_half = 1'b0;
                n_flags.overflow    = 1'b0;
                n_pos = (i_remaining == '0 || i_remaining > r_size) ? '0 : cnt;
            end
            REQ_STORE: begin
            end
            default: begin
                status = ST_NODATA;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= eff_size(CNT_W'(256));
            r_pos   <= '0;
            r_flags <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size <= eff_size(i_cfg_size);
            end
            if (i_accept) begin
                r_pos   <= n_pos;
                r_flags <= n_flags;
            end
        end
    end

    assign pos_ext  = 32'(r_pos);
    assign sidx_ext = 32'(i_store_index);

    // read the current position; the byte returns next cycle
    assign o_re    = i_accept && (i_req_type == REQ_READ);
    assign o_raddr = pos_ext[AW-1:0];
    assign o_we    = i_accept && (i_req_type == REQ_STORE) && (sidx_ext < RING_DEPTH);
    assign o_waddr = sidx_ext[AW-1:0];

    assign o_result.status = status;
    assign o_result.flags  = n_flags;

endmodule

// ===== hdl/dmarhf_out.sv =====
// ----------------------------------------------------------------------------
// dmarhf_out
// Read-data stage and output register; merges the store byte into the result.
// ----------------------------------------------------------------------------
module dmarhf_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  dmarhf_pkg::t_result                i_result,
    input  logic [dmarhf_pkg::BYTE_W-1:0]      i_rdata,
    output logic                               o_ready,
    output logic                               o_valid,
    input  logic                               i_tready,
    output dmarhf_pkg::t_result                o_result,
    output logic [dmarhf_pkg::BYTE_W-1:0]      o_data
);
    import dmarhf_pkg::*;

    logic              r_s1_valid;
    t_result           r_s1;
    logic              r_out_valid;
    t_result           r_out;
    logic [BYTE_W-1:0] r_out_data;
    logic              s1_move;

    assign s1_move = !r_out_valid || i_tready;
    assign o_ready = !r_s1_valid || s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (r_s1_valid && s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= i_result;
        end
        // store data is valid here: no new read is issued while stage 1 holds
        if (r_s1_valid && s1_move) begin
            r_out      <= r_s1;
            r_out_data <= (r_s1.status == ST_DATA) ? i_rdata : '0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign o_data   = r_out_data;

endmodule

// ===== hdl/dma_ring_half_flag_reader_top.sv =====
// ----------------------------------------------------------------------------
// dma_ring_half_flag_reader_top
// Read side of a DMA receive ring filled in two halves.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one item per request: tuser holds the request
//   kind (read, first half done, second half done, line idle, resync, store).
//   Every item yields exactly one result on the master stream: tuser holds the
//   status, tdata the byte read and the four ring flags after the item.
//   The config channel writes the ring size; write it only while idle.
// Timing:
//   One item per cycle sustained while tready stays high. Results pass the
//   read stage, where the byte store read is registered, then the output
//   register. Ring state updates at acceptance, so back-to-back reads see
//   each other; a store followed by a read of that byte is safe.
// Reset:
//   Synchronous, active low. Position and flags clear, ring size returns to
//   256 (limited to RING_DEPTH). The byte store keeps its contents.
// Stall:
//   While the receiver holds tready low, results wait in the output register
//   and read stage. Once both hold an item, tready drops in the same cycle,
//   so at most two more items are taken after the stall begins.
// ----------------------------------------------------------------------------
module dma_ring_half_flag_reader_top #(
    parameter int RING_DEPTH = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config: ring_size
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [dmarhf_pkg::CNT_W-1:0]         i_cfg_data,
    // slave stream
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: remaining[8:0], store_index[16:9], store_byte[24:17], zero fill
    input  logic [dmarhf_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [dmarhf_pkg::REQ_W-1:0]         i_s_axis_tuser,
    // master stream
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata: data[7:0], first_half_pending[8], second_half_pending[9],
    //        overflow_flag[10], idle_flag[11], zero fill
    output logic [dmarhf_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // tuser: status[1:0]
    output logic [dmarhf_pkg::STATUS_W-1:0]      o_m_axis_tuser
);
    import dmarhf_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    logic              accept;
    logic              ready;
    logic              we;
    logic [AW-1:0]     waddr;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [BYTE_W-1:0] rdata;
    t_result           result;
    t_result           out_result;
    logic [BYTE_W-1:0] out_data;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = ready;
    assign accept          = i_s_axis_tvalid && ready;

    dmarhf_ctrl #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_size    (i_cfg_data),
        .i_accept      (accept),
        .i_req_type    (i_s_axis_tuser),
        .i_remaining   (i_s_axis_tdata[8:0]),
        .i_store_index (i_s_axis_tdata[16:9]),
        .o_we          (we),
        .o_waddr       (waddr),
        .o_re          (re),
        .o_raddr       (raddr),
        .o_result      (result)
    );

    dmarhf_store #(
        .RING_DEPTH (RING_DEPTH),
        .AW         (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_s_axis_tdata[24:17]),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    dmarhf_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_result (result),
        .i_rdata  (rdata),
        .o_ready  (ready),
        .o_valid  (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_result (out_result),
        .o_data   (out_data)
    );

    assign o_m_axis_tdata = {4'b0000,
                             out_result.flags.idle,
                             out_result.flags.overflow,
                             out_result.flags.second_half,
                             out_result.flags.first_half,
                             out_data};
    assign o_m_axis_tuser = out_result.status;

endmodule

// ===== tb/ring_reader_checker.sv =====
// ----------------------------------------------------------------------------
// ring_reader_checker
// Watches the config, request and result streams of the DMA ring half-flag
// reader. It keeps its own copy of the ring (store, read position, flags,
// ring size) and works out the result of every request taken. Each result
// taken from the master stream is compared with the oldest one waiting.
// ----------------------------------------------------------------------------
module ring_reader_checker
    import dmarhf_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [CNT_W-1:0]       i_cfg_data,
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [IN_DATA_W-1:0]   i_s_tdata,
    input  logic [REQ_W-1:0]       i_s_tuser,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_DATA_W-1:0]  i_m_tdata,
    input  logic [STATUS_W-1:0]    i_m_tuser,
    output int                     o_mismatches,
    output int                     o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data;
        t_flags              flags;
    } t_ring_reply;

    logic [CNT_W-1:0]  ring_cfg = 9'd256;
    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    int                rd_pos = 0;
    t_flags            ring_flags = '0;
    t_ring_reply       replies_due [$];
    int                n_items = 0;
    int                n_results = 0;
    int                n_bad = 0;

    assign o_mismatches  = n_bad;
    assign o_outstanding = n_items - n_results;

    // bit 0 dropped, then held between 2 and the even part of the store depth
    function automatic int usable_size(logic [CNT_W-1:0] cfg);
        int s;
        s = int'(cfg) & 'h1FE;
        if (s < 2) s = 2;
        if (s > (RING_DEPTH & ~1)) s = RING_DEPTH & ~1;
        return s;
    endfunction

    function automatic t_ring_reply apply_request(logic [REQ_W-1:0] req,
                                                  logic [CNT_W-1:0] rem,
                                                  logic [BYTE_W-1:0] idx,
                                                  logic [BYTE_W-1:0] val);
        t_ring_reply reply;
        int          span;
        int          mid;
        int          left;
        logic        lower;
        logic        keep_idle;
        span = usable_size(ring_cfg);
        mid = span / 2;
        left = int'(rem);
        reply = '0;
        reply.status = ST_EVENT;
        case (req)
            REQ_READ: begin
                keep_idle = 1'b0;
                if (ring_flags.overflow) begin
                    reply.status = ST_OVF;
                end else begin
                    lower = rd_pos < mid;
                    if ((lower ? ring_flags.first_half : ring_flags.second_half) ||
                        (left < span && rd_pos < span - left)) begin
                        reply.status = ST_DATA;
                        reply.data = (rd_pos < RING_DEPTH) ? ring_mem[rd_pos] : '0;
                        rd_pos++;
                        if (lower) begin
                            if (rd_pos == mid) begin
                                ring_flags.first_half = 1'b0;
                                keep_idle = 1'b1;
                            end
                        end else if (rd_pos >= span) begin
                            rd_pos = 0;
                            ring_flags.second_half = 1'b0;
                            keep_idle = 1'b1;
                        end
                    end else begin
                        reply.status = ST_NODATA;
                    end
                end
                // a read that empties a half leaves the idle flag alone
                if (!keep_idle) ring_flags.idle = 1'b0;
            end
            REQ_FIRST, REQ_SECOND: begin
                if (req == REQ_FIRST) ring_flags.first_half = 1'b1;
                else ring_flags.second_half = 1'b1;
                if (ring_flags.first_half && ring_flags.second_half)
                    ring_flags.overflow = 1'b1;
            end
            REQ_IDLE: begin
                ring_flags.idle = 1'b1;
            end
            REQ_RESYNC: begin
                ring_flags.first_half = 1'b0;
                ring_flags.second_half = 1'b0;
                ring_flags.overflow = 1'b0;
                rd_pos = (left == 0 || left > span) ? 0 : span - left;
            end
            REQ_STORE: begin
                if (int'(idx) < RING_DEPTH) ring_mem[idx] = val;
            end
            default: begin
                reply.status = ST_NODATA;
            end
        endcase
        reply.flags = ring_flags;
        return reply;
    endfunction

    always @(posedge i_clk) begin
        t_ring_reply got;
        t_ring_reply want;
        if (!i_rst_n) begin
            ring_cfg = 9'd256;
            rd_pos = 0;
            ring_flags = '0;
            replies_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) ring_cfg = i_cfg_data;
            if (i_s_tvalid && i_s_tready) begin
                replies_due.push_back(apply_request(i_s_tuser, i_s_tdata[8:0],
                                                    i_s_tdata[16:9], i_s_tdata[24:17]));
                n_items <= n_items + 1;
            end
            if (i_m_tvalid && i_m_tready) begin
                got.status = i_m_tuser;
                got.data = i_m_tdata[7:0];
                got.flags.first_half = i_m_tdata[8];
                got.flags.second_half = i_m_tdata[9];
                got.flags.overflow = i_m_tdata[10];
                got.flags.idle = i_m_tdata[11];
                if (replies_due.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("ERROR: result with no item outstanding: status %0d tdata %h",
                                 i_m_tuser, i_m_tdata);
                end else begin
                    want = replies_due.pop_front();
                    n_results <= n_results + 1;
                    if (got.status !== want.status || got.data !== want.data ||
                        got.flags !== want.flags) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display({"ERROR: result %0d: expected status %0d data %h ",
                                      "flags %b, got status %0d data %h flags %b"},
                                     n_results, want.status, want.data, want.flags,
                                     got.status, got.data, got.flags);
                    end
                end
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the DMA ring half-flag reader. After reset the whole byte
// store is filled, then a directed run covers empty and full reads, half
// marks, overflow, idle, resync corners, unknown request kinds and a read
// past a shrunk ring. Random phases follow, one per ring size, each driving
// a DMA-like fill pass with reads in between plus some noise. Both streams
// pause at random; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb;
    import dmarhf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int               RING_DEPTH     = 256;
    localparam int               WATCHDOG_LIMIT = 4000;
    localparam logic [REQ_W-1:0] REQ_UNUSED_A   = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_B   = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CNT_W-1:0]      cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic [REQ_W-1:0]      s_user = '0;
    logic                  m_ready = 1'b0;
    logic                  cfg_ready;
    logic                  s_ready;
    logic                  m_valid;
    logic [OUT_DATA_W-1:0] m_data;
    logic [STATUS_W-1:0]   m_user;
    int                    mismatches;
    int                    outstanding;
    int                    quiet = 0;
    logic                  no_gaps = 1'b0;

    always #2 i_clk = ~i_clk;

    dma_ring_half_flag_reader_top #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    ring_reader_checker #(
        .RING_DEPTH(RING_DEPTH)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_data    (cfg_data),
        .i_s_tvalid    (s_valid),
        .i_s_tready    (s_ready),
        .i_s_tdata     (s_data),
        .i_s_tuser     (s_user),
        .i_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (m_data),
        .i_m_tuser     (m_user),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int ring_bytes(logic [CNT_W-1:0] cfg);
        int s;
        s = int'(cfg) & 'h1FE;
        if (s < 2) s = 2;
        if (s > (RING_DEPTH & ~1)) s = RING_DEPTH & ~1;
        return s;
    endfunction

    function automatic logic [CNT_W-1:0] noise_remaining();
        if ($urandom_range(0, 9) == 0) return CNT_W'($urandom_range(257, 511));
        return CNT_W'($urandom_range(0, 256));
    endfunction

    // valid stays high into the next item unless a gap is taken
    task automatic send_item(input logic [REQ_W-1:0] req, input logic [CNT_W-1:0] rem,
                             input logic [7:0] idx, input logic [7:0] val);
        int gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= req;
        s_data <= {7'd0, val, idx, rem};
        do @(posedge i_clk); while (!(s_valid && s_ready));
    endtask

    task automatic send_event(input logic [REQ_W-1:0] req, input logic [CNT_W-1:0] rem);
        send_item(req, rem, 8'($urandom), 8'($urandom));
    endtask

    // hold the sender until every result has come back
    task automatic wait_results();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic set_ring(input logic [CNT_W-1:0] v);
        wait_results();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge i_clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    // receiver: runs of ready, broken by stalls
    initial begin
        forever begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 99) < 85) repeat ($urandom_range(1, 6)) @(posedge i_clk);
            else repeat ($urandom_range(30, 90)) @(posedge i_clk);
            m_ready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("FAIL dma_ring_half_flag_reader_top");
            $finish;
        end
    end

    initial begin
        int                ring_plan [10];
        logic [CNT_W-1:0]  cfg;
        int                span;
        int                fill;
        int                r;
        ring_plan = '{2, 511, 0, 4, 3, 1, 257, -1, -2, 256};

        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;

        // fill the whole store so no read ever sees an unwritten entry
        for (int i = 0; i < RING_DEPTH; i++)
            send_item(REQ_STORE, CNT_W'($urandom), 8'(i), 8'($urandom));

        // directed: ring size 256 from reset
        send_event(REQ_READ, 9'd256);            // nothing filled
        send_event(REQ_READ, 9'd255);            // one byte filled
        send_event(REQ_IDLE, 9'd0);
        send_event(REQ_READ, 9'd256);            // no data, idle drops
        send_item(REQ_STORE, 9'd0, 8'hFF, 8'hFF);
        send_item(REQ_STORE, 9'd0, 8'h00, 8'h00);
        send_event(REQ_RESYNC, 9'd0);
        send_event(REQ_RESYNC, 9'd300);
        send_event(REQ_RESYNC, 9'd256);
        send_event(REQ_FIRST, 9'd0);
        send_event(REQ_READ, 9'd256);            // delivered on the half flag
        send_event(REQ_RESYNC, 9'd129);          // to the last byte of the first half
        send_event(REQ_FIRST, 9'd0);
        send_event(REQ_IDLE, 9'd0);
        send_event(REQ_READ, 9'd256);            // leaves the first half, idle held
        send_event(REQ_RESYNC, 9'd1);            // to the last byte of the ring
        send_event(REQ_SECOND, 9'd0);
        send_event(REQ_IDLE, 9'd0);
        send_event(REQ_READ, 9'd256);            // wraps, idle held
        send_event(REQ_FIRST, 9'd0);
        send_event(REQ_SECOND, 9'd0);            // both halves full: overflow
        send_event(REQ_READ, 9'd0);
        send_event(REQ_UNUSED_A, 9'd511);
        send_event(REQ_UNUSED_B, 9'd0);
        send_event(REQ_RESYNC, 9'd56);           // read position 200
        send_event(REQ_SECOND, 9'd0);
        set_ring(9'd8);
        send_event(REQ_READ, 9'd8);              // position past the shrunk ring

        // random phases, one per ring size
        for (int p = 0; p < 10; p++) begin
            if (ring_plan[p] == -1) cfg = CNT_W'(2 * $urandom_range(4, 127));
            else if (ring_plan[p] == -2) cfg = CNT_W'($urandom_range(0, 511));
            else cfg = CNT_W'(ring_plan[p]);
            set_ring(cfg);
            span = ring_bytes(cfg);
            no_gaps = (p % 3 == 1);
            fill = 0;
            send_event(REQ_RESYNC, CNT_W'(span));
            repeat (36) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    // DMA writes the next byte and marks a half when done
                    send_item(REQ_STORE, CNT_W'($urandom), 8'(fill), 8'($urandom));
                    fill++;
                    if (fill == span / 2) send_event(REQ_FIRST, CNT_W'(span - fill));
                    if (fill == span) begin
                        send_event(REQ_SECOND, CNT_W'(span));
                        fill = 0;
                    end
                end else if (r < 70) begin
                    send_event(REQ_READ, CNT_W'(span - fill));
                end else if (r < 78) begin
                    send_event(REQ_IDLE, noise_remaining());
                end else if (r < 82) begin
                    send_event(REQ_RESYNC, CNT_W'(span - fill));
                end else begin
                    send_item(REQ_W'($urandom_range(0, 7)), noise_remaining(),
                              8'($urandom), 8'($urandom));
                end
                if ($urandom_range(0, 99) == 0) wait_results();
            end
        end

        wait_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS dma_ring_half_flag_reader_top");
        else
            $display("FAIL dma_ring_half_flag_reader_top");
        $finish;
    end

endmodule
